// ----- src/mrf_pkg.sv -----
package mrf_pkg;

    // Result kinds carried on the master-side tuser
    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  FUNC_COILS = 8'h01;
    localparam logic [8:0]  LEN_MAX    = 9'd511;
    localparam logic [2:0]  FRAME_LAST = 3'd7;

    // Fields of a read request
    typedef struct packed {
        logic [7:0]  slave_address;
        logic [7:0]  func_code;
        logic [15:0] start_address;
        logic [10:0] quantity;
    } req_t;

    // One result beat
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       crc_error;
        logic       last;
    } beat_t;

    // Fold one byte into a CRC-16/MODBUS (reflected) remainder
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- src/mrf_req.sv -----
module mrf_req (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  mrf_pkg::req_t  req,
    input  logic           adv,
    output logic           busy,
    output mrf_pkg::beat_t beat
);

    logic              busy_reg;
    logic [2:0]        cnt_reg;
    logic [5:0][7:0]   frame_reg;
    logic [15:0]       crc_reg;
    logic [7:0]        cur_byte;
    logic              emit;

    assign busy = busy_reg;
    assign emit = busy_reg && adv;

    // Pick the frame byte for the current position; CRC low byte goes first
    always_comb
    begin
        case (cnt_reg)
            3'd0:    cur_byte = frame_reg[0];
            3'd1:    cur_byte = frame_reg[1];
            3'd2:    cur_byte = frame_reg[2];
            3'd3:    cur_byte = frame_reg[3];
            3'd4:    cur_byte = frame_reg[4];
            3'd5:    cur_byte = frame_reg[5];
            3'd6:    cur_byte = crc_reg[7:0];
            default: cur_byte = crc_reg[15:8];
        endcase
    end

    always_comb
    begin
        beat.kind      = mrf_pkg::KIND_TX;
        beat.data_byte = cur_byte;
        beat.crc_error = 1'b0;
        beat.last      = (cnt_reg == mrf_pkg::FRAME_LAST);
    end

    // Sequence the eight transmit beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 3'd0;
        end
        else if (emit)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == mrf_pkg::FRAME_LAST)
                busy_reg <= 1'b0;
        end
    end

    // Hold the header bytes and accumulate the CRC as they go out
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg[0] <= req.slave_address;
            frame_reg[1] <= req.func_code;
            frame_reg[2] <= req.start_address[15:8];
            frame_reg[3] <= req.start_address[7:0];
            frame_reg[4] <= {5'd0, req.quantity[10:8]};
            frame_reg[5] <= req.quantity[7:0];
            crc_reg      <= mrf_pkg::CRC_INIT;
        end
        else if (emit && cnt_reg < 3'd6)
        begin
            crc_reg <= mrf_pkg::crc_byte(crc_reg, cur_byte);
        end
    end

endmodule

// ----- src/mrf_rsp.sv -----
module mrf_rsp (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [7:0]     func_code,
    input  logic [10:0]    quantity,
    input  logic           byte_en,
    input  logic [7:0]     rx_byte,
    output logic           res_valid,
    output mrf_pkg::beat_t res
);

    logic [15:0] crc_reg;
    logic [8:0]  len_reg;
    logic [8:0]  cnt_reg;
    logic [7:0]  crc_low_reg;
    logic        wait_reg;

    logic [12:0] len_raw;
    logic [8:0]  len_next;
    logic [9:0]  p_plus2;
    logic [9:0]  p_plus3;
    logic        in_body;
    logic        at_crc_low;
    logic        is_payload;

    // Expected response length, saturated to the counter range
    always_comb
    begin
        if (func_code == mrf_pkg::FUNC_COILS)
            len_raw = 13'd5 + {4'd0, 9'((13'({2'd0, quantity}) + 13'd7) >> 3)};
        else
            len_raw = 13'd5 + {1'b0, quantity, 1'b0};
        if (len_raw > 13'(mrf_pkg::LEN_MAX))
            len_next = mrf_pkg::LEN_MAX;
        else
            len_next = len_raw[8:0];
    end

    // Classify the byte position within the response
    assign p_plus2    = {1'b0, cnt_reg} + 10'd2;
    assign p_plus3    = {1'b0, cnt_reg} + 10'd3;
    assign in_body    = p_plus2 < {1'b0, len_reg};
    assign at_crc_low = p_plus2 == {1'b0, len_reg};
    assign is_payload = in_body && (cnt_reg >= 9'd3) && (p_plus3 <= {1'b0, len_reg});

    always_comb
    begin
        res_valid     = 1'b0;
        res.kind      = mrf_pkg::KIND_DATA;
        res.data_byte = rx_byte;
        res.crc_error = 1'b0;
        res.last      = 1'b0;
        if (byte_en && wait_reg)
        begin
            if (in_body)
            begin
                res_valid = is_payload;
            end
            else if (!at_crc_low)
            begin
                res_valid     = 1'b1;
                res.kind      = mrf_pkg::KIND_STATUS;
                res.data_byte = 8'd0;
                res.crc_error = ({rx_byte, crc_low_reg} != crc_reg);
                res.last      = 1'b1;
            end
        end
    end

    // Track the response: restart on a request, advance on each byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= mrf_pkg::CRC_INIT;
            len_reg     <= 9'd0;
            cnt_reg     <= 9'd0;
            crc_low_reg <= 8'd0;
            wait_reg    <= 1'b0;
        end
        else if (start)
        begin
            crc_reg     <= mrf_pkg::CRC_INIT;
            len_reg     <= len_next;
            cnt_reg     <= 9'd0;
            crc_low_reg <= 8'd0;
            wait_reg    <= 1'b1;
        end
        else if (byte_en && wait_reg)
        begin
            cnt_reg <= cnt_reg + 9'd1;
            if (in_body)
                crc_reg <= mrf_pkg::crc_byte(crc_reg, rx_byte);
            else if (at_crc_low)
                crc_low_reg <= rx_byte;
            else
                wait_reg <= 1'b0;
        end
    end

endmodule

// ----- src/modbus_rtu_read_framer.sv -----
// Modbus RTU read master framer. A request beat (tuser = 0) becomes eight
// transmit beats on the master side: address, function, start address,
// quantity, then the CRC-16/MODBUS low byte and high byte, the eighth beat
// flagged with tlast. Each request first loads the frame serializer and then
// sends its beats, one per cycle while the master side is ready; input stalls
// meanwhile. The response is then fed one byte per beat (tuser = 1), at one
// beat per cycle while the master side is ready: payload bytes come out with
// kind 1, and after the final CRC byte a status beat (kind 2, tlast) carries
// crc_error. A response byte arriving when no response is awaited is dropped;
// a new request abandons any pending response. A request passes through the
// input register and the frame serializer to the output register; a response
// byte goes from the input register straight to the output register.
module modbus_rtu_read_framer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] slave_address, [15:8] func_code, [31:16] start_address,
    // [42:32] quantity, [50:43] rx_byte, [55:51] zero
    input  logic [55:0] s_axis_tdata,
    // [0] mode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_byte, [8] crc_error, [15:9] zero
    output logic [15:0] m_axis_tdata,
    // [1:0] kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic           in_valid_reg;
    logic           in_mode_reg;
    logic [50:0]    in_data_reg;
    logic           out_valid_reg;
    mrf_pkg::beat_t out_beat_reg;

    mrf_pkg::req_t  req;
    mrf_pkg::beat_t req_beat;
    mrf_pkg::beat_t rsp_beat;
    logic           req_busy;
    logic           rsp_valid;
    logic           out_free;
    logic           take;
    logic           req_load;
    logic           byte_en;

    assign out_free = !out_valid_reg || m_axis_tready;

    // Consume the held beat: requests wait for the serializer, bytes also for the output
    assign take     = in_valid_reg && !req_busy && (!in_mode_reg || out_free);
    assign req_load = take && !in_mode_reg;
    assign byte_en  = take && in_mode_reg;

    assign s_axis_tready = !in_valid_reg || take;

    assign req.slave_address = in_data_reg[7:0];
    assign req.func_code     = in_data_reg[15:8];
    assign req.start_address = in_data_reg[31:16];
    assign req.quantity      = in_data_reg[42:32];

    // Hold the incoming beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_mode_reg <= s_axis_tuser;
            in_data_reg <= s_axis_tdata[50:0];
        end
    end

    mrf_req u_req (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (req_load),
        .req   (req),
        .adv   (out_free),
        .busy  (req_busy),
        .beat  (req_beat)
    );

    mrf_rsp u_rsp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_load),
        .func_code (req.func_code),
        .quantity  (req.quantity),
        .byte_en   (byte_en),
        .rx_byte   (in_data_reg[50:43]),
        .res_valid (rsp_valid),
        .res       (rsp_beat)
    );

    // Output register: serializer beats, else response results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= req_busy || (byte_en && rsp_valid);
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (req_busy)
                out_beat_reg <= req_beat;
            else
                out_beat_reg <= rsp_beat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_beat_reg.crc_error, out_beat_reg.data_byte};
    assign m_axis_tuser  = out_beat_reg.kind;
    assign m_axis_tlast  = out_beat_reg.last;

endmodule
